// ===== design/three_axis_pid_with_integral_clamp_core_defines.svh =====
// assertion macros for the three-axis pid core and its checker
// no dependencies; included by the checker file
`ifndef THREE_AXIS_PID_WITH_INTEGRAL_CLAMP_CORE_DEFINES_SVH
`define THREE_AXIS_PID_WITH_INTEGRAL_CLAMP_CORE_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define TAPID_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TAPID_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tapid_pkg.sv =====
// shared types, widths and field offsets for the three-axis pid core
// no dependencies; used by every module of the core
`default_nettype none

package tapid_pkg;

    localparam int AXES_DEF     = 3;
    localparam int NUM_CARRIERS = 3;
    localparam int FIELD_W      = 24;
    localparam int GAIN_W       = 16;
    localparam int LIM_W        = 21;
    localparam int DT_W         = 16;
    localparam int DRIVE_W      = 32;
    localparam int GAIN_REG_W   = 48;
    localparam int LIM_REG_W    = 63;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 232;
    localparam int OUT_TDATA_W  = 104;
    localparam int FF_LSB       = 0;
    localparam int PE_LSB       = 72;
    localparam int DE_LSB       = 144;
    localparam int DT_LSB       = 216;
    localparam int MASK_LSB     = 96;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_GAINS,
        REG_I_GAINS,
        REG_D_GAINS,
        REG_INTEG_LIMITS
    } tapid_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INTEG,
        ST_IMUL,
        ST_SUM,
        ST_OUT
    } tapid_state_t;

    typedef struct packed {
        logic mul_en;
        logic integ_en;
        logic imul_en;
        logic sum_en;
        logic clr;
    } tapid_lane_ctl_t;

endpackage

`default_nettype wire

// ===== design/tapid_lane.sv =====
// one pid axis: integral update with clamp, gain products, round and saturate
// depends on tapid_pkg
`default_nettype none

module tapid_lane (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  tapid_pkg::tapid_lane_ctl_t               ctl,
    input  wire signed [tapid_pkg::FIELD_W-1:0]      ff,
    input  wire signed [tapid_pkg::FIELD_W-1:0]      ep,
    input  wire signed [tapid_pkg::FIELD_W-1:0]      ed,
    input  wire        [tapid_pkg::DT_W-1:0]         dt,
    input  wire        [tapid_pkg::GAIN_W-1:0]       kp,
    input  wire        [tapid_pkg::GAIN_W-1:0]       ki,
    input  wire        [tapid_pkg::GAIN_W-1:0]       kd,
    input  wire        [tapid_pkg::LIM_W-1:0]        lim,
    output logic signed [tapid_pkg::DRIVE_W-1:0]     drive,
    output logic                                     clamped
);

    localparam int PROD_W = 41;
    localparam int INC_W  = 25;
    localparam int SUM_W  = 26;
    localparam int ACC_W  = 44;
    localparam int RND_W  = 36;

    logic signed [PROD_W-1:0]                 mp_reg, pp_reg, dp_reg, ip_reg;
    logic signed [tapid_pkg::FIELD_W-1:0]     integ_reg, integ_next;
    logic                                     clamp_reg, clamp_next;
    logic signed [ACC_W-1:0]                  base_reg, base_next;
    logic signed [tapid_pkg::DRIVE_W-1:0]     drive_reg, drive_next;

    logic signed [PROD_W-1:0]  inc_full;
    logic signed [INC_W-1:0]   inc;
    logic signed [SUM_W-1:0]   s_sum, lim_pos, lim_neg, s_clamped;
    logic signed [ACC_W-1:0]   acc, rnd_full;
    logic signed [RND_W-1:0]   rnd;

    // integral step: round dt * error to q12.12, add, clamp
    always_comb begin
        inc_full = mp_reg + PROD_W'(32768);
        inc      = inc_full[PROD_W-1:16];
        s_sum    = {{(SUM_W-tapid_pkg::FIELD_W){integ_reg[tapid_pkg::FIELD_W-1]}}, integ_reg}
                 + {inc[INC_W-1], inc};
        lim_pos  = {{(SUM_W-tapid_pkg::LIM_W){1'b0}}, lim};
        lim_neg  = -lim_pos;
        if (s_sum > lim_pos) begin
            s_clamped  = lim_pos;
            clamp_next = 1'b1;
        end else if (s_sum < lim_neg) begin
            s_clamped  = lim_neg;
            clamp_next = 1'b1;
        end else begin
            s_clamped  = s_sum;
            clamp_next = 1'b0;
        end
        integ_next = s_clamped[tapid_pkg::FIELD_W-1:0];
        if (ctl.clr) begin
            integ_next = '0;
            clamp_next = 1'b0;
        end
        base_next = {{(ACC_W-tapid_pkg::FIELD_W-8){ff[tapid_pkg::FIELD_W-1]}}, ff, 8'h00}
                  + {{(ACC_W-PROD_W){pp_reg[PROD_W-1]}}, pp_reg}
                  + {{(ACC_W-PROD_W){dp_reg[PROD_W-1]}}, dp_reg};
    end

    // output: add integral term, round half up by 8 bits, saturate
    always_comb begin
        acc      = base_reg + {{(ACC_W-PROD_W){ip_reg[PROD_W-1]}}, ip_reg};
        rnd_full = acc + ACC_W'(128);
        rnd      = rnd_full[ACC_W-1:8];
        if (rnd[RND_W-1:tapid_pkg::DRIVE_W-1] == '0 ||
            rnd[RND_W-1:tapid_pkg::DRIVE_W-1] == '1) begin
            drive_next = rnd[tapid_pkg::DRIVE_W-1:0];
        end else if (rnd[RND_W-1]) begin
            drive_next = {1'b1, {(tapid_pkg::DRIVE_W-1){1'b0}}};
        end else begin
            drive_next = {1'b0, {(tapid_pkg::DRIVE_W-1){1'b1}}};
        end
        if (ctl.clr) begin
            drive_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (ctl.integ_en) begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            mp_reg <= PROD_W'(ep) * PROD_W'($signed({1'b0, dt}));
            pp_reg <= PROD_W'(ep) * PROD_W'($signed({1'b0, kp}));
            dp_reg <= PROD_W'(ed) * PROD_W'($signed({1'b0, kd}));
        end
        if (ctl.integ_en) begin
            clamp_reg <= clamp_next;
            base_reg  <= base_next;
        end
        if (ctl.imul_en) begin
            ip_reg <= PROD_W'(integ_reg) * PROD_W'($signed({1'b0, ki}));
        end
        if (ctl.sum_en) begin
            drive_reg <= drive_next;
        end
    end

    assign drive   = drive_reg;
    assign clamped = clamp_reg;

endmodule

`default_nettype wire

// ===== design/tapid_merge.sv =====
// merge stage: packs the lane results into the output word and holds it
// depends on tapid_pkg
`default_nettype none

module tapid_merge (
    input  wire                                                     aclk,
    input  wire                                                     aresetn,
    input  wire                                                     load,
    input  wire [tapid_pkg::NUM_CARRIERS*tapid_pkg::DRIVE_W-1:0]    drive_bus,
    input  wire [tapid_pkg::NUM_CARRIERS-1:0]                       mask,
    output logic                                                    m_axis_tvalid,
    input  wire                                                     m_axis_tready,
    output logic [tapid_pkg::OUT_TDATA_W-1:0]                       m_axis_tdata
);

    localparam int PAD_W = tapid_pkg::OUT_TDATA_W - tapid_pkg::MASK_LSB
                         - tapid_pkg::NUM_CARRIERS;

    logic                                 valid_reg, valid_next;
    logic [tapid_pkg::OUT_TDATA_W-1:0]    data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {{PAD_W{1'b0}}, mask, drive_bus};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

`default_nettype wire

// ===== design/three_axis_pid_with_integral_clamp_core.sv =====
// top level of the three-axis pid core with integral clamp
// depends on tapid_pkg, tapid_lane, tapid_merge
//
//   channel  | ports               | word
//   ---------+---------------------+-----------------------------------------
//   input    | s_axis_*            | tuser cmd, tdata ff, prop err, deriv err, dt
//   result   | m_axis_*            | tdata drive x, y, z, clamp mask
//   config   | cfg_we/index/wdata  | p gains, i gains, d gains, integral limits
//
// each word passes through these steps in order: accept, four lane steps (products, integral clamp,
// integral gain product, sum and saturate), then the load of the output register
// one shared lane control from the sequencer steps every lane; lanes run in parallel per axis
// a stalled result holds the sequencer in its last step, s_axis_tready is low
// until the word is loaded
// synchronous active-low reset clears integrals, gains, limits and valid flags
`default_nettype none

module three_axis_pid_with_integral_clamp_core #(
    parameter int AXES = tapid_pkg::AXES_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // ff_x, ff_y, ff_z, prop_err_x, prop_err_y, prop_err_z,
    // deriv_err_x, deriv_err_y, deriv_err_z, step_time
    input  wire [tapid_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // cmd
    input  wire                                   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // drive_x, drive_y, drive_z, clamp_mask, zero pad
    output logic [tapid_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                   cfg_we,
    input  wire [tapid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [tapid_pkg::LIM_REG_W-1:0]        cfg_wdata
);

    localparam int LIVE_AXES = (AXES < tapid_pkg::NUM_CARRIERS) ? AXES
                                                               : tapid_pkg::NUM_CARRIERS;

    tapid_pkg::tapid_state_t            state_reg, state_next;
    tapid_pkg::tapid_lane_ctl_t         lane_ctl;
    logic                               merge_load;

    logic [tapid_pkg::IN_TDATA_W-1:0]   in_data_reg;
    logic                               in_clr_reg;
    logic [tapid_pkg::GAIN_REG_W-1:0]   p_gains_reg, i_gains_reg, d_gains_reg;
    logic [tapid_pkg::LIM_REG_W-1:0]    integ_limits_reg;

    logic [tapid_pkg::NUM_CARRIERS*tapid_pkg::DRIVE_W-1:0]  drive_bus;
    logic [tapid_pkg::NUM_CARRIERS-1:0]                     mask;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gains_reg      <= '0;
            i_gains_reg      <= '0;
            d_gains_reg      <= '0;
            integ_limits_reg <= '0;
        end else if (cfg_we) begin
            case (tapid_pkg::tapid_reg_t'(cfg_index))
                tapid_pkg::REG_P_GAINS: begin
                    p_gains_reg <= cfg_wdata[tapid_pkg::GAIN_REG_W-1:0];
                end
                tapid_pkg::REG_I_GAINS: begin
                    i_gains_reg <= cfg_wdata[tapid_pkg::GAIN_REG_W-1:0];
                end
                tapid_pkg::REG_D_GAINS: begin
                    d_gains_reg <= cfg_wdata[tapid_pkg::GAIN_REG_W-1:0];
                end
                tapid_pkg::REG_INTEG_LIMITS: begin
                    integ_limits_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata;
            in_clr_reg  <= s_axis_tuser;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tapid_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tapid_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = tapid_pkg::ST_MUL;
                end
            end
            tapid_pkg::ST_MUL:   state_next = tapid_pkg::ST_INTEG;
            tapid_pkg::ST_INTEG: state_next = tapid_pkg::ST_IMUL;
            tapid_pkg::ST_IMUL:  state_next = tapid_pkg::ST_SUM;
            tapid_pkg::ST_SUM:   state_next = tapid_pkg::ST_OUT;
            tapid_pkg::ST_OUT: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    state_next = tapid_pkg::ST_IDLE;
                end
            end
            default: state_next = tapid_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready     = 1'b0;
        merge_load        = 1'b0;
        lane_ctl          = '0;
        lane_ctl.clr      = in_clr_reg;
        case (state_reg)
            tapid_pkg::ST_IDLE:  s_axis_tready     = 1'b1;
            tapid_pkg::ST_MUL:   lane_ctl.mul_en   = 1'b1;
            tapid_pkg::ST_INTEG: lane_ctl.integ_en = 1'b1;
            tapid_pkg::ST_IMUL:  lane_ctl.imul_en  = 1'b1;
            tapid_pkg::ST_SUM:   lane_ctl.sum_en   = 1'b1;
            tapid_pkg::ST_OUT:   merge_load        = !m_axis_tvalid || m_axis_tready;
            default: begin
            end
        endcase
    end

    // axis lanes
    for (genvar i = 0; i < tapid_pkg::NUM_CARRIERS; i++) begin : g_lane
        if (i < LIVE_AXES) begin : g_live
            logic signed [tapid_pkg::DRIVE_W-1:0] lane_drive;
            tapid_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (lane_ctl),
                .ff      ($signed(in_data_reg[tapid_pkg::FF_LSB + tapid_pkg::FIELD_W*i
                                              +: tapid_pkg::FIELD_W])),
                .ep      ($signed(in_data_reg[tapid_pkg::PE_LSB + tapid_pkg::FIELD_W*i
                                              +: tapid_pkg::FIELD_W])),
                .ed      ($signed(in_data_reg[tapid_pkg::DE_LSB + tapid_pkg::FIELD_W*i
                                              +: tapid_pkg::FIELD_W])),
                .dt      (in_data_reg[tapid_pkg::DT_LSB +: tapid_pkg::DT_W]),
                .kp      (p_gains_reg[tapid_pkg::GAIN_W*i +: tapid_pkg::GAIN_W]),
                .ki      (i_gains_reg[tapid_pkg::GAIN_W*i +: tapid_pkg::GAIN_W]),
                .kd      (d_gains_reg[tapid_pkg::GAIN_W*i +: tapid_pkg::GAIN_W]),
                .lim     (integ_limits_reg[tapid_pkg::LIM_W*i +: tapid_pkg::LIM_W]),
                .drive   (lane_drive),
                .clamped (mask[i])
            );
            assign drive_bus[tapid_pkg::DRIVE_W*i +: tapid_pkg::DRIVE_W] = lane_drive;
        end else begin : g_absent
            assign drive_bus[tapid_pkg::DRIVE_W*i +: tapid_pkg::DRIVE_W] = '0;
            assign mask[i] = 1'b0;
        end
    end

    tapid_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (merge_load),
        .drive_bus     (drive_bus),
        .mask          (mask),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== design/tapid_check.sv =====
// port-level checker for the three-axis pid core, bound to the top level
// depends on tapid_pkg and the defines header
`default_nettype none
`include "three_axis_pid_with_integral_clamp_core_defines.svh"

module tapid_check (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 s_axis_tvalid,
    input wire                                 s_axis_tready,
    input wire                                 m_axis_tvalid,
    input wire                                 m_axis_tready,
    input wire [tapid_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // no result word survives reset
    `TAPID_ASSERT_RST(a_reset_clears_out, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    // a stalled result word holds
    `TAPID_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // an accepted word keeps the input closed through the lane steps
    `TAPID_ASSERT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready, "input reopened early")

    // a new result word only appears at the end of a busy period
    `TAPID_ASSERT(a_out_after_work, aclk, aresetn, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without work")

endmodule

bind three_axis_pid_with_integral_clamp_core tapid_check u_tapid_check (.*);

`default_nettype wire
